@@ src/vkms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkms_pkg
// Shared types, constants and controller/datapath signal groups for the
// two-contact velocity keyboard matrix scanner.
// ----------------------------------------------------------------------------
package vkms_pkg;

  // Matrix and key space
  localparam int ROWS     = 16;
  localparam int KEYS     = 128;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int KEY_W    = $clog2(KEYS);
  localparam int COLS     = 16;
  localparam int COL_W    = 4;

  // Pin map limits (rows valid for each half, right half offset)
  localparam logic [3:0] LEFT_LAST_ROW  = 4'd9;
  localparam logic [3:0] RIGHT_LAST_ROW = 4'd11;
  localparam int         RIGHT_OFFSET   = 80;

  // Note and velocity constants
  localparam int NOTE_BASE = 21;
  localparam int NOTE_MAX  = 127;
  localparam int VEL_MAX   = 127;

  // Divider: numerator magnitude |delay - fastest| * 127 stays below 2^38
  localparam int NUM_W     = 39;
  localparam int SPAN_W    = 17;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // Config port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FASTEST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST = 4'd1;
  localparam logic [15:0] FASTEST_RESET = 16'd4;
  localparam logic [15:0] SLOWEST_RESET = 16'd200;

  // Event kinds
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_OFF  = 2'd2;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [15:0] column_bits;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] midi_note;
    logic [6:0] velocity;
    logic       last_of_row;
  } out_item_t;

  // What the current changed column means
  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_FIRST_PRESS,
    CLS_FIRST_RELEASE,
    CLS_SECOND_PRESS
  } col_cls_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_READ,
    ST_DIFF,
    ST_ABS,
    ST_DIVLOAD,
    ST_DIV,
    ST_STASH,
    ST_FLUSH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_row;
    logic col_done;
    logic mem_write;
    logic mem_read;
    logic clr_valid;
    logic latch_ev;
    logic vel_delay;
    logic vel_diff;
    logic vel_abs;
    logic div_load;
    logic div_step;
    logic stash;
    logic flush;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic     any_left;
    col_cls_t cls;
    logic     stored_set;
    logic     div_busy;
    logic     pend_valid;
    logic     slot_free;
  } sts_t;

endpackage
`default_nettype wire

@@ src/vkms_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkms_ctrl
// Sequencer: accepts a row, walks its changed columns one at a time, runs
// the velocity divider for note-ons and hands events to the datapath.
// ----------------------------------------------------------------------------
module vkms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vkms_pkg::sts_t sts,
  output vkms_pkg::cmd_t      cmd
);

  vkms_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vkms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      vkms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = vkms_pkg::ST_LOAD;
        end
      end
      vkms_pkg::ST_LOAD: begin
        cmd.load_row = 1'b1;
        state_nxt    = vkms_pkg::ST_SCAN;
      end
      vkms_pkg::ST_SCAN: begin
        if (!sts.any_left) begin
          state_nxt = vkms_pkg::ST_FLUSH;
        end else begin
          cmd.col_done = 1'b1;
          unique case (sts.cls)
            vkms_pkg::CLS_FIRST_PRESS: begin
              cmd.mem_write = 1'b1;
            end
            vkms_pkg::CLS_FIRST_RELEASE: begin
              cmd.clr_valid = 1'b1;
              cmd.latch_ev  = 1'b1;
              state_nxt     = vkms_pkg::ST_STASH;
            end
            vkms_pkg::CLS_SECOND_PRESS: begin
              cmd.mem_read = 1'b1;
              cmd.latch_ev = 1'b1;
              state_nxt    = vkms_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      vkms_pkg::ST_READ: begin
        // no captured first contact: nothing to report
        if (sts.stored_set) begin
          cmd.vel_delay = 1'b1;
          state_nxt     = vkms_pkg::ST_DIFF;
        end else begin
          state_nxt = vkms_pkg::ST_SCAN;
        end
      end
      vkms_pkg::ST_DIFF: begin
        cmd.vel_diff = 1'b1;
        state_nxt    = vkms_pkg::ST_ABS;
      end
      vkms_pkg::ST_ABS: begin
        cmd.vel_abs = 1'b1;
        state_nxt   = vkms_pkg::ST_DIVLOAD;
      end
      vkms_pkg::ST_DIVLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = vkms_pkg::ST_DIV;
      end
      vkms_pkg::ST_DIV: begin
        if (sts.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          state_nxt = vkms_pkg::ST_STASH;
        end
      end
      vkms_pkg::ST_STASH: begin
        // the held event moves out only when the output slot can take it
        if (!sts.pend_valid || sts.slot_free) begin
          cmd.stash = 1'b1;
          state_nxt = vkms_pkg::ST_SCAN;
        end
      end
      vkms_pkg::ST_FLUSH: begin
        if (sts.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = vkms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vkms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/vkms_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkms_dpath
// Row pattern store, press time memory, column decode, velocity
// arithmetic with a bit-serial divider, held event and output register.
// ----------------------------------------------------------------------------
module vkms_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire vkms_pkg::cmd_t                    cmd,
  output vkms_pkg::sts_t                         sts,
  input  wire vkms_pkg::in_item_t                in_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vkms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output vkms_pkg::out_item_t                    out_data
);

  // Captured row item
  logic [3:0]  row_r;
  logic [15:0] bits_r;
  logic [31:0] time_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r  <= in_data.row_index;
      bits_r <= in_data.column_bits;
      time_r <= in_data.time_ms;
    end
  end

  // Config registers
  logic [15:0] fastest_r, slowest_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fastest_r <= vkms_pkg::FASTEST_RESET;
      slowest_r <= vkms_pkg::SLOWEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vkms_pkg::CFG_FASTEST: fastest_r <= cfg_data;
        vkms_pkg::CFG_SLOWEST: slowest_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Row patterns and changed-column mask
  logic [15:0]               pat_r [vkms_pkg::ROWS];
  logic [15:0]               changed_r;
  logic                      row_ok;
  logic [vkms_pkg::ROW_W-1:0] row_idx;

  assign row_ok  = {1'b0, row_r} < 5'(vkms_pkg::ROWS);
  assign row_idx = row_r[vkms_pkg::ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vkms_pkg::ROWS; i++) begin
        pat_r[i] <= 16'hFFFF;
      end
      changed_r <= '0;
    end else if (cmd.load_row) begin
      if (row_ok) begin
        changed_r      <= bits_r ^ pat_r[row_idx];
        pat_r[row_idx] <= bits_r;
      end else begin
        changed_r <= '0;
      end
    end else if (cmd.col_done) begin
      // drop the lowest set bit
      changed_r <= changed_r & (changed_r - 16'd1);
    end
  end

  // Lowest changed column
  logic [vkms_pkg::COL_W-1:0] col;

  always_comb begin
    col = '0;
    for (int i = vkms_pkg::COLS - 1; i >= 0; i--) begin
      if (changed_r[i]) begin
        col = vkms_pkg::COL_W'(i);
      end
    end
  end

  // Pin map and classification
  logic [6:0]                 pin_base;
  logic [7:0]                 pin;
  logic [6:0]                 key_raw;
  logic [vkms_pkg::KEY_W-1:0] key_idx;
  logic                       mapped, key_ok, released;
  logic [7:0]                 note_sum;
  logic [6:0]                 note;
  vkms_pkg::col_cls_t         cls;

  assign pin_base = {row_r[3:1], col[2:0], row_r[0]};
  assign pin      = col[3] ? {1'b0, pin_base} + 8'(vkms_pkg::RIGHT_OFFSET) : {1'b0, pin_base};
  assign key_raw  = pin[7:1];
  assign key_idx  = key_raw[vkms_pkg::KEY_W-1:0];
  assign mapped   = col[3] ? (row_r <= vkms_pkg::RIGHT_LAST_ROW)
                           : (row_r <= vkms_pkg::LEFT_LAST_ROW);
  assign key_ok   = {1'b0, key_raw} < 8'(vkms_pkg::KEYS);
  assign released = bits_r[col];
  assign note_sum = {1'b0, key_raw} + 8'(vkms_pkg::NOTE_BASE);
  assign note     = (note_sum > 8'(vkms_pkg::NOTE_MAX)) ? 7'(vkms_pkg::NOTE_MAX)
                                                         : note_sum[6:0];

  // even pin is the first contact; a released second contact is dropped
  always_comb begin
    if (!mapped || !key_ok) begin
      cls = vkms_pkg::CLS_SKIP;
    end else if (!released) begin
      cls = pin[0] ? vkms_pkg::CLS_SECOND_PRESS : vkms_pkg::CLS_FIRST_PRESS;
    end else begin
      cls = pin[0] ? vkms_pkg::CLS_SKIP : vkms_pkg::CLS_FIRST_RELEASE;
    end
  end

  // Press time memory, registered read
  logic [31:0]               press_mem [vkms_pkg::KEYS];
  logic [31:0]               mem_q_r;
  logic [vkms_pkg::KEYS-1:0] vld_r;
  logic                      vld_q_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      press_mem[key_idx] <= time_r;
    end
    if (cmd.mem_read) begin
      mem_q_r <= press_mem[key_idx];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (cmd.mem_write) begin
        vld_r[key_idx] <= 1'b1;
      end else if (cmd.clr_valid) begin
        vld_r[key_idx] <= 1'b0;
      end
      if (cmd.mem_read) begin
        vld_q_r <= vld_r[key_idx];
      end
    end
  end

  // Event being built
  logic [1:0] ev_kind_r;
  logic [6:0] note_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_ev) begin
      ev_kind_r <= (cls == vkms_pkg::CLS_FIRST_RELEASE) ? vkms_pkg::EV_OFF : vkms_pkg::EV_ON;
      note_r    <= note;
    end
  end

  // Velocity pre-steps: delay, delay - fastest, sign/magnitude
  logic [31:0]        delay_r;
  logic signed [32:0] dmf_r;
  logic [32:0]        mag_r;
  logic               num_neg_r;

  always_ff @(posedge clk) begin
    if (cmd.vel_delay) begin
      delay_r <= time_r - mem_q_r;
    end
    if (cmd.vel_diff) begin
      dmf_r <= $signed({delay_r[31], delay_r}) - $signed({17'd0, fastest_r});
    end
    if (cmd.vel_abs) begin
      num_neg_r <= dmf_r[32];
      mag_r     <= dmf_r[32] ? 33'(-dmf_r) : 33'(dmf_r);
    end
  end

  // Span = slowest - fastest as sign and magnitude
  logic [vkms_pkg::SPAN_W-1:0] span;
  logic [vkms_pkg::SPAN_W-1:0] span_mag;
  logic                        span_zero;
  logic [39:0]                 num_prod;

  assign span      = {1'b0, slowest_r} - {1'b0, fastest_r};
  assign span_mag  = span[vkms_pkg::SPAN_W-1] ? (~span + 1'b1) : span;
  assign span_zero = (slowest_r == fastest_r);
  assign num_prod  = {mag_r, 7'd0} - {7'd0, mag_r};   // |delay - fastest| * 127

  // Restoring divider, one quotient bit a cycle
  logic [vkms_pkg::NUM_W-1:0]     quo_r;
  logic [vkms_pkg::SPAN_W-1:0]    rem_r;
  logic [vkms_pkg::SPAN_W-1:0]    dvs_r;
  logic                           q_neg_r;
  logic                           zero_r;
  logic [vkms_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [vkms_pkg::SPAN_W:0]      trial;
  logic [vkms_pkg::SPAN_W:0]      trial_sub;

  assign trial     = {rem_r, quo_r[vkms_pkg::NUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r   <= num_prod[vkms_pkg::NUM_W-1:0];
      rem_r   <= '0;
      dvs_r   <= span_mag;
      q_neg_r <= num_neg_r ^ span[vkms_pkg::SPAN_W-1];
      zero_r  <= span_zero;
    end else if (cmd.div_step) begin
      if (!trial_sub[vkms_pkg::SPAN_W]) begin
        rem_r <= trial_sub[vkms_pkg::SPAN_W-1:0];
        quo_r <= {quo_r[vkms_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[vkms_pkg::SPAN_W-1:0];
        quo_r <= {quo_r[vkms_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_load) begin
      cnt_r <= vkms_pkg::DIV_CNT_W'(vkms_pkg::NUM_W);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Velocity = 127 - q, clamped to 1..127
  logic [6:0] vel;

  always_comb begin
    if (zero_r || q_neg_r || (quo_r == '0)) begin
      vel = 7'(vkms_pkg::VEL_MAX);
    end else if (quo_r >= vkms_pkg::NUM_W'(vkms_pkg::VEL_MAX)) begin
      vel = 7'd1;
    end else begin
      vel = 7'(vkms_pkg::VEL_MAX) - quo_r[6:0];
    end
  end

  // Held event: last_of_row is known only once the next one shows up
  vkms_pkg::out_item_t pend_r, new_item, push_item, none_item;
  logic                pend_valid_r;
  logic                push;
  logic                out_valid_r;
  vkms_pkg::out_item_t out_data_r;

  always_comb begin
    new_item             = '0;
    new_item.event_kind  = ev_kind_r;
    new_item.midi_note   = note_r;
    new_item.velocity    = (ev_kind_r == vkms_pkg::EV_ON) ? vel : 7'd0;
    new_item.last_of_row = 1'b0;

    none_item             = '0;
    none_item.event_kind  = vkms_pkg::EV_NONE;
    none_item.last_of_row = 1'b1;

    push_item = pend_r;
    if (cmd.flush) begin
      push_item             = pend_valid_r ? pend_r : none_item;
      push_item.last_of_row = 1'b1;
    end
  end

  assign push = (cmd.stash && pend_valid_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.stash) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stash) begin
      pend_r <= new_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status
  always_comb begin
    sts            = '0;
    sts.any_left   = |changed_r;
    sts.cls        = cls;
    sts.stored_set = vld_q_r && (mem_q_r != 32'd0);
    sts.div_busy   = (cnt_r != '0);
    sts.pend_valid = pend_valid_r;
    sts.slot_free  = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

@@ src/velocity_keyboard_matrix_scanner.sv @@
// Throughput: one row item at a time. A changed column with no event or a
//   first-contact press ends in the scan state; a note-off or unstamped second
//   contact passes stash or read; a note-on runs setup, the divider, stash.
// Output: a row's last result is registered on leaving flush; out_ready
//   stalls hold a finished event. Reset (synchronous, rst_n low): rows
//   released, no press times, fastest_delay = 4, slowest_delay = 200.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_keyboard_matrix_scanner
// Two-contact velocity keyboard scanner: turns scanned matrix rows into
// note-on / note-off events with contact-delay velocity.
// ----------------------------------------------------------------------------
module velocity_keyboard_matrix_scanner (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire vkms_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output vkms_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vkms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);

  vkms_pkg::cmd_t cmd;
  vkms_pkg::sts_t sts;

  // Sequencer
  vkms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  vkms_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ src/vkms_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vkms_checker
// Port-level checks for the velocity keyboard scanner, bound to the top.
// ----------------------------------------------------------------------------
module vkms_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire vkms_pkg::out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One row item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while a row is in work");

  // A quiet result is the last one of its row and carries no note or velocity
  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == vkms_pkg::EV_NONE |->
      out_data.last_of_row && out_data.midi_note == 7'd0 && out_data.velocity == 7'd0)
    else $error("malformed quiet result");

  // Note-on carries a velocity, note-off none
  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.event_kind == vkms_pkg::EV_ON && out_data.velocity != 7'd0) ||
      (out_data.event_kind == vkms_pkg::EV_OFF && out_data.velocity == 7'd0) ||
      (out_data.event_kind == vkms_pkg::EV_NONE))
    else $error("velocity does not match event kind");

endmodule

bind velocity_keyboard_matrix_scanner vkms_checker u_vkms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the velocity keyboard matrix scanner. Row scans go
// in over a valid/ready channel and a scoreboard class mirrors the scanner:
// stored row patterns, per-key first-contact times and the velocity formula.
// The predicted note events are queued and every result item that leaves the
// block is compared field by field with the oldest one. Stimulus is a
// directed pass over the corner cases and then random key strokes, chords and
// noise rows under several delay settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_LIMIT = 100;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 13;

  // Mirror of the scanner: predicts note events per scanned row
  class note_scoreboard;
    logic [15:0]         row_pat  [vkms_pkg::ROWS];
    logic [31:0]         press_ms [vkms_pkg::KEYS];
    logic [15:0]         fastest;
    logic [15:0]         slowest;
    vkms_pkg::out_item_t expected_events [$];
    int                  errors;

    function new();
      foreach (row_pat[i]) row_pat[i] = 16'hFFFF;
      foreach (press_ms[k]) press_ms[k] = '0;
      fastest = vkms_pkg::FASTEST_RESET;
      slowest = vkms_pkg::SLOWEST_RESET;
      errors  = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int pending();
      return expected_events.size();
    endfunction

    function void write_reg(input logic [vkms_pkg::CFG_IDX_W-1:0] idx,
                            input logic [15:0] value);
      if (idx == vkms_pkg::CFG_FASTEST) fastest = value;
      else if (idx == vkms_pkg::CFG_SLOWEST) slowest = value;
    endfunction

    // Signed contact delay mapped linearly onto 1..127
    function logic [6:0] velocity_for(input logic [31:0] now_t, input logic [31:0] pressed_t);
      logic [31:0] diff;
      longint      delay;
      longint      span;
      longint      v;
      diff  = now_t - pressed_t;
      delay = longint'($signed(diff));
      span  = longint'(slowest) - longint'(fastest);
      if (span == 0) return 7'(vkms_pkg::VEL_MAX);
      v = vkms_pkg::VEL_MAX - ((delay - longint'(fastest)) * vkms_pkg::VEL_MAX) / span;
      if (v < 1) v = 1;
      if (v > vkms_pkg::VEL_MAX) v = vkms_pkg::VEL_MAX;
      return 7'(v);
    endfunction

    // Walk the changed columns of one accepted row item
    function void note_row(input vkms_pkg::in_item_t it);
      logic [3:0]          row;
      logic [3:0]          c;
      logic [15:0]         changed;
      logic [7:0]          pin;
      logic [6:0]          key;
      logic                mapped;
      int                  note_i;
      vkms_pkg::out_item_t ev;
      vkms_pkg::out_item_t held;
      bit                  have_held;
      row       = it.row_index;
      have_held = 1'b0;
      held      = '0;
      changed   = it.column_bits ^ row_pat[row];
      row_pat[row] = it.column_bits;
      for (int col = 0; col < vkms_pkg::COLS; col++) begin
        c = 4'(col);
        if (!changed[c]) continue;
        if (c < 8) begin
          mapped = (row <= vkms_pkg::LEFT_LAST_ROW);
          pin    = {1'b0, row[3:1], c[2:0], row[0]};
        end else begin
          mapped = (row <= vkms_pkg::RIGHT_LAST_ROW);
          pin    = 8'(vkms_pkg::RIGHT_OFFSET) + {1'b0, row[3:1], c[2:0], row[0]};
        end
        if (!mapped) continue;
        if (int'(pin >> 1) >= vkms_pkg::KEYS) continue;
        key    = pin[7:1];
        note_i = vkms_pkg::NOTE_BASE + int'(key);
        if (note_i > vkms_pkg::NOTE_MAX) note_i = vkms_pkg::NOTE_MAX;
        ev.event_kind  = vkms_pkg::EV_NONE;
        ev.midi_note   = 7'(note_i);
        ev.velocity    = '0;
        ev.last_of_row = 1'b0;
        if (!it.column_bits[c]) begin
          // press: first contact stamps, second contact fires if stamped
          if (!pin[0]) begin
            press_ms[key] = it.time_ms;
          end else if (press_ms[key] != 0) begin
            ev.event_kind = vkms_pkg::EV_ON;
            ev.velocity   = velocity_for(it.time_ms, press_ms[key]);
          end
        end else if (!pin[0]) begin
          press_ms[key] = '0;
          ev.event_kind = vkms_pkg::EV_OFF;
        end
        if (ev.event_kind != vkms_pkg::EV_NONE) begin
          if (have_held) expected_events.push_back(held);
          held      = ev;
          have_held = 1'b1;
        end
      end
      // quiet row: one empty result
      if (!have_held) begin
        held.event_kind = vkms_pkg::EV_NONE;
        held.midi_note  = '0;
        held.velocity   = '0;
      end
      held.last_of_row = 1'b1;
      expected_events.push_back(held);
    endfunction

    task check_result(input vkms_pkg::out_item_t got);
      vkms_pkg::out_item_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected result kind %0d note %0d vel %0d last %0d",
                         got.event_kind, got.midi_note, got.velocity, got.last_of_row));
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report($sformatf("event_kind %0d, expected %0d", got.event_kind, want.event_kind));
      if (got.midi_note !== want.midi_note)
        report($sformatf("midi_note %0d, expected %0d", got.midi_note, want.midi_note));
      if (got.velocity !== want.velocity)
        report($sformatf("velocity %0d, expected %0d", got.velocity, want.velocity));
      if (got.last_of_row !== want.last_of_row)
        report($sformatf("last_of_row %0d, expected %0d", got.last_of_row, want.last_of_row));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  vkms_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  vkms_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [vkms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  note_scoreboard sb;
  logic [15:0]    cur_pat [vkms_pkg::ROWS];
  logic [31:0]    now_ms;
  bit             no_idle = 1'b0;
  int             items_sent = 0;
  int unsigned    cycle_count = 0;

  velocity_keyboard_matrix_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_delay();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 300);
    if (pick < 8) return $urandom_range(0, 70000);
    if (pick == 8) return $urandom;
    return '0;
  endfunction

  // Offer one row item; valid stays up only if the next item follows at once
  task automatic send_row(input logic [3:0] row, input logic [15:0] bits,
                          input logic [31:0] stamp);
    vkms_pkg::in_item_t it;
    int                 gap;
    it.row_index   = row;
    it.column_bits = bits;
    it.time_ms     = stamp;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    cur_pat[row] = bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_row(it);
    items_sent++;
  endtask

  // Hold off input until every predicted result has left the block
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [vkms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Press one or more keys of a row pair: first contact, second contact,
  // then usually release in random order
  task automatic play_chord();
    logic [3:0]  r;
    logic [3:0]  r2;
    logic [15:0] allowed;
    logic [15:0] mask;
    r  = 4'(2 * $urandom_range(0, 5));
    r2 = 4'(r + 1);
    allowed = (r2 <= vkms_pkg::LEFT_LAST_ROW) ? 16'hFFFF : 16'hFF00;
    if ($urandom_range(0, 3) == 0)
      mask = 16'($urandom) & allowed;
    else
      mask = 16'h1 << $urandom_range((allowed == 16'hFFFF) ? 0 : 8, 15);
    if (mask == 0) mask = 16'h8000;
    now_ms += $urandom_range(1, 40);
    send_row(r, cur_pat[r] & ~mask, now_ms);
    now_ms += pick_delay();
    send_row(r2, cur_pat[r2] & ~mask, now_ms);
    if ($urandom_range(0, 3) != 0) begin
      now_ms += $urandom_range(1, 200);
      if ($urandom_range(0, 1)) begin
        send_row(r, cur_pat[r] | mask, now_ms);
        send_row(r2, cur_pat[r2] | mask, now_ms + 1);
      end else begin
        send_row(r2, cur_pat[r2] | mask, now_ms);
        send_row(r, cur_pat[r] | mask, now_ms + 1);
      end
    end
  endtask

  task automatic send_noise();
    logic [31:0] stamp;
    stamp = $urandom_range(0, 1) ? $urandom : now_ms;
    send_row(4'($urandom_range(0, 15)), 16'($urandom), stamp);
  endtask

  // Result side: random stalls; no new ones start while no_idle is set
  initial begin
    int   stall_left;
    int   pick;
    logic rdy;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (no_idle) begin
        rdy = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        rdy  = 1'b0;
        if (pick < 70) rdy = 1'b1;
        else if (pick < 95) stall_left = $urandom_range(0, 3);
        else stall_left = $urandom_range(10, 60);
      end
      out_ready <= rdy;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    logic [15:0]                    fast_set [PHASES];
    logic [15:0]                    slow_set [PHASES];
    logic [vkms_pkg::CFG_IDX_W-1:0] bad_idx;
    int                             target;
    int                             pick;
    sb = new();
    foreach (cur_pat[i]) cur_pat[i] = 16'hFFFF;
    now_ms = 32'd100;
    fast_set[0] = 16'd0;      slow_set[0] = 16'd65535;
    fast_set[1] = 16'd65535;  slow_set[1] = 16'd0;
    fast_set[2] = 16'd300;    slow_set[2] = 16'd300;
    fast_set[3] = vkms_pkg::FASTEST_RESET; slow_set[3] = vkms_pkg::SLOWEST_RESET;
    fast_set[4] = 16'($urandom_range(0, 400));
    slow_set[4] = 16'($urandom_range(0, 400));
    fast_set[5] = 16'd10;     slow_set[5] = 16'd11;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset delays
    send_row(4'd0, 16'hFFFF, 32'd100);                      // quiet row
    send_row(4'd0, 16'hFFFE, 32'd1000);                     // first contact
    send_row(4'd1, 16'hFFFE, 32'd1010);                     // note on
    send_row(4'd1, 16'hFFFF, 32'd1020);                     // second released
    send_row(4'd0, 16'hFFFF, 32'd1030);                     // note off
    send_row(4'd3, 16'hFFFB, 32'd1040);                     // second, no stamp
    send_row(4'd2, 16'hFFFD, 32'd0);                        // stamp at time zero
    send_row(4'd3, 16'hFFF9, 32'd5);                        // still no event
    send_row(4'd2, cur_pat[2] & ~16'h0010, 32'd6000);
    send_row(4'd3, cur_pat[3] & ~16'h0010, 32'd6004);       // delay equals fastest
    send_row(4'd10, 16'hFFFE, 32'd60);                      // left half, unmapped row
    send_row(4'd12, 16'h0000, 32'd70);                      // both halves unmapped
    send_row(4'd15, 16'h0000, 32'hFFFF_0000);
    send_row(4'd10, cur_pat[10] & ~16'h8000, 32'd2000);     // top key, right half
    send_row(4'd11, cur_pat[11] & ~16'h8000, 32'd2900);     // slow: clamps low
    send_row(4'd10, cur_pat[10] | 16'h8000, 32'd2950);
    send_row(4'd6, cur_pat[6] & ~16'h0008, 32'd5000);
    send_row(4'd7, cur_pat[7] & ~16'h0008, 32'd4000);       // negative delay
    send_row(4'd8, cur_pat[8] & ~16'h0080, 32'hFFFF_FFF0);
    send_row(4'd9, cur_pat[9] & ~16'h0080, 32'h0000_0005);  // time wrap
    send_row(4'd4, 16'h0000, 32'd3000);                     // sixteen stamps
    send_row(4'd5, 16'h0000, 32'd3050);                     // sixteen note-ons
    send_row(4'd4, 16'hFFFF, 32'd3100);                     // sixteen note-offs
    send_row(4'd5, 16'hFFFF, 32'd3110);
    now_ms = 32'd8000;

    // Random strokes and noise under each delay setting
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle = 1'b0;
      wait_for_results();
      cfg_write(vkms_pkg::CFG_FASTEST, fast_set[ph]);
      cfg_write(vkms_pkg::CFG_SLOWEST, slow_set[ph]);
      if (ph == 2) begin
        bad_idx = vkms_pkg::CFG_IDX_W'($urandom_range(int'(vkms_pkg::CFG_SLOWEST) + 1,
                                                      (1 << vkms_pkg::CFG_IDX_W) - 1));
        cfg_write(bad_idx, 16'($urandom));
      end
      no_idle = (ph == 3);
      target  = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          play_chord();
        end else if (pick < 95) begin
          send_noise();
        end else begin
          now_ms = $urandom;
          send_noise();
        end
      end
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
